// ===== src/hls_to_rgb_converter_macros.svh =====
// Assertion macros shared by the HSL to RGB converter RTL.
`ifndef HLS_TO_RGB_CONVERTER_MACROS_SVH
`define HLS_TO_RGB_CONVERTER_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define H2R_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define H2R_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/h2r_pkg.sv =====
// Shared types and constants for the HSL to RGB converter.
package h2r_pkg;

  // Fraction bits of lightness, saturation, hue and the color channels.
  localparam int FRAC_BITS = 16;
  localparam int HUE_W     = FRAC_BITS + 2;
  // Width of v1, v2, their difference and the ramp factor.
  localparam int CH_W      = FRAC_BITS + 1;

  // Input word: one color in HSL form.
  typedef struct packed {
    logic signed [HUE_W-1:0]     hue;
    logic        [FRAC_BITS-1:0] lightness;
    logic        [FRAC_BITS-1:0] saturation;
  } h2r_in_t;

  // Output word: one color in RGB form.
  typedef struct packed {
    logic [FRAC_BITS-1:0] red;
    logic [FRAC_BITS-1:0] green;
    logic [FRAC_BITS-1:0] blue;
  } h2r_out_t;

  // Hue sector of one channel.
  typedef enum logic [1:0] {
    SEC_RISE,
    SEC_TOP,
    SEC_FALL,
    SEC_BASE
  } h2r_sec_t;

  // Per-channel sector and ramp factor.
  typedef struct packed {
    h2r_sec_t             sec;
    logic [CH_W-1:0]      factor;
  } h2r_lane_t;

  // Values shared by all three channels.
  typedef struct packed {
    logic                 grey;
    logic [FRAC_BITS-1:0] lightness;
    logic [CH_W-1:0]      v1;
    logic [CH_W-1:0]      v2;
    logic [CH_W-1:0]      d;
  } h2r_base_t;

  // Advance enables, one per pipeline stage.
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } h2r_adv_t;

endpackage

// ===== src/h2r_front.sv =====
// Front stages: hue wrap, L*S product, v1/v2 and per-channel sector decode.
module h2r_front (
  input  logic                    clk,
  input  h2r_pkg::h2r_adv_t       adv,
  input  h2r_pkg::h2r_in_t        in_word,
  output h2r_pkg::h2r_base_t      base_r,
  output h2r_pkg::h2r_lane_t [2:0] lane_r
);

  localparam int F  = h2r_pkg::FRAC_BITS;
  localparam int HW = F + 3;
  localparam int UW = F + 4;

  localparam logic signed [HW-1:0] HX_ONE  = HW'(1) << F;
  localparam logic        [F-1:0]  HALF_F  = F'(1) << (F - 1);
  localparam logic        [2*F:0]  RND     = (2*F+1)'(1) << (F - 1);
  localparam logic signed [UW-1:0] U_ONE   = UW'(1) << F;
  localparam logic signed [UW-1:0] U_THREE = UW'(3) << F;
  localparam logic        [F+2:0]  C_ONE   = (F+3)'(1) << F;
  localparam logic        [F+2:0]  C_THREE = (F+3)'(3) << F;
  localparam logic        [F+2:0]  C_FOUR  = (F+3)'(4) << F;
  localparam logic        [F+1:0]  C_TWO   = (F+2)'(2) << F;

  // Wrap a channel's hue position into one turn and pick its sector.
  function automatic h2r_pkg::h2r_lane_t decode_lane(input logic signed [UW-1:0] u_in);
    logic signed [UW-1:0] u;
    logic        [F+1:0]  uw;
    logic        [F+2:0]  u2;
    logic        [F+2:0]  fall;
    h2r_pkg::h2r_lane_t   lane;
    u = u_in;
    if (u < 0) begin
      u = u + U_THREE;
    end else if (u > U_THREE) begin
      u = u - U_THREE;
    end
    uw = u[F+1:0];
    u2 = {uw, 1'b0};
    fall = C_FOUR - u2;
    lane.factor = '0;
    if (u2 < C_ONE) begin
      lane.sec    = h2r_pkg::SEC_RISE;
      lane.factor = u2[F:0];
    end else if (u2 < C_THREE) begin
      lane.sec    = h2r_pkg::SEC_TOP;
    end else if (uw < C_TWO) begin
      lane.sec    = h2r_pkg::SEC_FALL;
      lane.factor = fall[F:0];
    end else begin
      lane.sec    = h2r_pkg::SEC_BASE;
    end
    return lane;
  endfunction

  // Stage 1 logic: wrap the hue once and form the lightness-saturation product.
  logic signed [HW-1:0] hx;
  logic [F:0]           h_nxt;
  logic [F:0]           h_r;
  logic [F-1:0]         l_r;
  logic [F-1:0]         s_r;
  logic [2*F-1:0]       prod_nxt;
  logic [2*F-1:0]       prod_r;
  logic                 grey_r;

  always_comb begin
    hx = {in_word.hue[h2r_pkg::HUE_W-1], in_word.hue};
    if (hx < 0) begin
      hx = hx + HX_ONE;
    end else if (hx > HX_ONE) begin
      hx = hx - HX_ONE;
    end
    // A hue still below zero keeps only its fraction bits.
    if (hx < 0) begin
      hx = {{(HW-F){1'b0}}, hx[F-1:0]};
    end
    h_nxt    = hx[F:0];
    prod_nxt = in_word.lightness * in_word.saturation;
  end

  always_ff @(posedge clk) begin
    if (adv.s1) begin
      h_r    <= h_nxt;
      l_r    <= in_word.lightness;
      s_r    <= in_word.saturation;
      prod_r <= prod_nxt;
      grey_r <= (in_word.saturation == '0);
    end
  end

  // Stage 2 logic: round L*S, form v2 and v1, and decode the three hue sectors.
  logic [2*F:0]         rnd_sum;
  logic [F:0]           ls;
  logic [F+1:0]         v2a;
  logic signed [F+2:0]  v1a;
  logic [F:0]           v1;
  logic [F:0]           v2;
  logic [F+2:0]         h3;
  logic signed [UW-1:0] u_mid;
  h2r_pkg::h2r_base_t   base_nxt;
  h2r_pkg::h2r_lane_t [2:0] lane_nxt;

  always_comb begin
    rnd_sum = {1'b0, prod_r} + RND;
    ls      = rnd_sum[2*F:F];
    if (l_r <= HALF_F) begin
      v2a = (F+2)'(l_r) + (F+2)'(ls);
    end else begin
      v2a = (F+2)'(l_r) + (F+2)'(s_r) - (F+2)'(ls);
    end
    v1a = $signed({2'b00, l_r, 1'b0}) - $signed({1'b0, v2a});
    v1  = v1a[F+2] ? '0 : v1a[F:0];
    v2  = (v2a < {1'b0, v1}) ? v1 : v2a[F:0];

    base_nxt.grey      = grey_r;
    base_nxt.lightness = l_r;
    base_nxt.v1        = v1;
    base_nxt.v2        = v2;
    base_nxt.d         = v2 - v1;

    // Hue position times three; red leads by a third, blue trails by a third.
    h3          = {1'b0, h_r, 1'b0} + {2'b00, h_r};
    u_mid       = $signed({1'b0, h3});
    lane_nxt[0] = decode_lane(u_mid + U_ONE);
    lane_nxt[1] = decode_lane(u_mid);
    lane_nxt[2] = decode_lane(u_mid - U_ONE);
  end

  always_ff @(posedge clk) begin
    if (adv.s2) begin
      base_r <= base_nxt;
      lane_r <= lane_nxt;
    end
  end

endmodule

// ===== src/h2r_chan.sv =====
// Back stages of one color channel: ramp multiply, round, select and clamp.
module h2r_chan (
  input  logic                         clk,
  input  h2r_pkg::h2r_adv_t            adv,
  input  h2r_pkg::h2r_base_t           base,
  input  h2r_pkg::h2r_lane_t           lane,
  output logic [h2r_pkg::FRAC_BITS-1:0] chan_r
);

  localparam int F  = h2r_pkg::FRAC_BITS;
  localparam int CW = h2r_pkg::CH_W;

  localparam logic [2*CW:0] RND    = (2*CW+1)'(1) << (F - 1);
  localparam logic [F+2:0]  CH_MAX = (F+3)'({F{1'b1}});

  // Stage 3: scale the v2 - v1 swing by the ramp factor.
  logic [2*CW-1:0]   prod_nxt;
  logic [2*CW-1:0]   prod_r;
  h2r_pkg::h2r_sec_t sec_r;
  logic [CW-1:0]     v1_r;
  logic [CW-1:0]     v2_r;
  logic              grey_r;
  logic [F-1:0]      l_r;

  assign prod_nxt = base.d * lane.factor;

  always_ff @(posedge clk) begin
    if (adv.s3) begin
      prod_r <= prod_nxt;
      sec_r  <= lane.sec;
      v1_r   <= base.v1;
      v2_r   <= base.v2;
      grey_r <= base.grey;
      l_r    <= base.lightness;
    end
  end

  // Stage 4: round the ramp, pick the sector value and clamp to full scale, or pass the lightness for grey.
  logic [2*CW:0] rnd_sum;
  logic [F+2:0]  ramp;
  logic [F+2:0]  level;
  logic [F-1:0]  chan_nxt;

  always_comb begin
    rnd_sum = {1'b0, prod_r} + RND;
    ramp    = {2'b00, v1_r} + rnd_sum[2*CW:F];
    unique case (sec_r)
      h2r_pkg::SEC_RISE: level = ramp;
      h2r_pkg::SEC_FALL: level = ramp;
      h2r_pkg::SEC_TOP:  level = {2'b00, v2_r};
      h2r_pkg::SEC_BASE: level = {2'b00, v1_r};
    endcase
    if (grey_r) begin
      chan_nxt = l_r;
    end else if (level > CH_MAX) begin
      chan_nxt = CH_MAX[F-1:0];
    end else begin
      chan_nxt = level[F-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv.s4) begin
      chan_r <= chan_nxt;
    end
  end

endmodule

// ===== src/hls_to_rgb_converter.sv =====
// An accepted input word passes through the stage 1, 2, 3 and 4 registers to become its output word.
// Throughput: one word per cycle while the output is not held; each of the four stages advances on its own.
// Stalls: a held output backs up only the stages behind it, bubbles are squeezed out.
// Reset clears the stage valid bits and the output valid; data registers are not reset.
// The slowest stage is the channel ramp multiply of 17 x 17 bits.
`include "hls_to_rgb_converter_macros.svh"

// Top level of the HSL to RGB converter pipeline.
module hls_to_rgb_converter (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  h2r_pkg::h2r_in_t  in_word,
  output logic              out_valid,
  input  logic              out_stall,
  output h2r_pkg::h2r_out_t out_word
);

  localparam int F = h2r_pkg::FRAC_BITS;

  logic [2:0]                vld_r;
  logic                      out_valid_r;
  h2r_pkg::h2r_adv_t         adv;
  h2r_pkg::h2r_base_t        base;
  h2r_pkg::h2r_lane_t [2:0]  lane;
  logic [F-1:0]              ch_val [3];

  // A stage advances when it is empty or the stage after it advances.
  always_comb begin
    adv.s4 = !out_valid_r || !out_stall;
    adv.s3 = !vld_r[2] || adv.s4;
    adv.s2 = !vld_r[1] || adv.s3;
    adv.s1 = !vld_r[0] || adv.s2;
  end

  assign in_stall  = !adv.s1;
  assign out_valid = out_valid_r;

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv.s1) begin
        vld_r[0] <= in_valid;
      end
      if (adv.s2) begin
        vld_r[1] <= vld_r[0];
      end
      if (adv.s3) begin
        vld_r[2] <= vld_r[1];
      end
      if (adv.s4) begin
        out_valid_r <= vld_r[2];
      end
    end
  end

  // Shared front stages.
  h2r_front u_front (
    .clk     (clk),
    .adv     (adv),
    .in_word (in_word),
    .base_r  (base),
    .lane_r  (lane)
  );

  // One back end per channel: red, green, blue.
  for (genvar c = 0; c < 3; c++) begin : g_chan
    h2r_chan u_chan (
      .clk    (clk),
      .adv    (adv),
      .base   (base),
      .lane   (lane[c]),
      .chan_r (ch_val[c])
    );
  end

  assign out_word.red   = ch_val[0];
  assign out_word.green = ch_val[1];
  assign out_word.blue  = ch_val[2];

  // Back-pressure on the input comes only from a held output word.
  `H2R_ASSERT_NOW(a_stall_origin, in_stall, out_valid && out_stall, "stall without held word")
  // An accepted word occupies the first stage in the next cycle.
  `H2R_ASSERT_NEXT(a_accept_enters, in_valid && !in_stall, vld_r[0], "word not in stage one")
  // A full pipeline behind a held output keeps all of its words.
  `H2R_ASSERT_NEXT(a_full_holds, in_stall, (&vld_r) && out_valid, "word lost while stalled")

endmodule
